### rtl/core/sound_sweep_envelope_sequencer_macros.svh
// Assertion macros used by the sequencer core (sse_core).
// SSE_ASSERT_NOW  : consequent checked in the same cycle as the antecedent.
// SSE_ASSERT_NEXT : consequent checked in the cycle after the antecedent.
`ifndef SOUND_SWEEP_ENVELOPE_SEQUENCER_MACROS_SVH
`define SOUND_SWEEP_ENVELOPE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

`define SSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`else

`define SSE_ASSERT_NOW(label, clk, rst, ante, cons)

`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/sse_pkg.sv
package sse_pkg;

  // Field widths
  localparam int FreqW   = 11;
  localparam int VolW    = 4;
  localparam int CyclesW = 6;
  localparam int SweepW  = 18;
  localparam int EnvW    = 20;
  localparam int NumEnv  = 3;

  localparam logic [FreqW-1:0] FreqMax = 11'd2047;
  localparam logic [VolW-1:0]  VolMax  = 4'd15;

  // Sweep fires when count*5 > period*163566 (32713.2 cycles per unit)
  localparam logic [20:0] SweepUnit = 21'd163566;

  // Commands carried in tuser
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_LOAD_FREQ = 2'd1,
    CMD_LOAD_VOL  = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  // Envelope channel selectors
  localparam logic [1:0] CH_SQUARE1 = 2'd0;
  localparam logic [1:0] CH_SQUARE2 = 2'd1;
  localparam logic [1:0] CH_NOISE   = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SWEEP_PERIOD   = 3'd0;
  localparam logic [2:0] REG_SWEEP_SHIFT    = 3'd1;
  localparam logic [2:0] REG_SWEEP_SUBTRACT = 3'd2;
  localparam logic [2:0] REG_SQ1_ENV_PERIOD = 3'd3;
  localparam logic [2:0] REG_SQ2_ENV_PERIOD = 3'd4;
  localparam logic [2:0] REG_NOISE_ENV_PER  = 3'd5;
  localparam logic [2:0] REG_ENV_RISE_MASK  = 3'd6;

  typedef struct packed {
    logic [2:0]        sweep_period;
    logic [2:0]        sweep_shift;
    logic              sweep_subtract;
    logic [NumEnv-1:0][2:0] env_period;
    logic [NumEnv-1:0] env_rise_mask;
  } cfg_t;

  typedef struct packed {
    logic              square1_stopped;
    logic              freq_updated;
    logic [VolW-1:0]   noise_volume;
    logic [VolW-1:0]   square2_volume;
    logic [VolW-1:0]   square1_volume;
    logic [FreqW-1:0]  square1_freq;
  } res_t;

endpackage

### rtl/core/sound_sweep_envelope_sequencer.sv
// Channel   Ports                          Fields, lowest bit up
// s (in)    s_tvalid s_tready s_tdata      cycles, load_value, env_channel
//           s_tuser                        command
// m (out)   m_tvalid m_tready m_tdata      square1_freq, square1_volume,
//                                          square2_volume, noise_volume,
//                                          freq_updated, square1_stopped
// cfg       psel penable pwrite paddr pwdata prdata pready (registers at 4*i)
//
// One item per cycle sustained while m_tready stays high; an accepted input transaction
// passes the input register and then the result register, where its result is presented.
// The per-item update is one pass of timer adds, compares and the sweep adder.
// rst is synchronous and active high; it clears state and valid flags.
// While a result waits with m_tready low, one more item enters the input
// register, then s_tready drops until the result register drains.
module sound_sweep_envelope_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // cycles[5:0], load_value[16:6], env_channel[18:17]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // square1_freq[10:0], square1_volume[14:11],
                                 // square2_volume[18:15], noise_volume[22:19],
                                 // freq_updated[23], square1_stopped[24]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sse_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  sse_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_cycles (s_tdata[5:0]),
    .in_load   (s_tdata[16:6]),
    .in_chan   (s_tdata[18:17]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  sse_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### rtl/core/sse_cfg.sv
module sse_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sse_pkg::cfg_t cfg
);
  import sse_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SWEEP_PERIOD:   cfg.sweep_period   <= pwdata[2:0];
        REG_SWEEP_SHIFT:    cfg.sweep_shift    <= pwdata[2:0];
        REG_SWEEP_SUBTRACT: cfg.sweep_subtract <= pwdata[0];
        REG_SQ1_ENV_PERIOD: cfg.env_period[0]  <= pwdata[2:0];
        REG_SQ2_ENV_PERIOD: cfg.env_period[1]  <= pwdata[2:0];
        REG_NOISE_ENV_PER:  cfg.env_period[2]  <= pwdata[2:0];
        REG_ENV_RISE_MASK:  cfg.env_rise_mask  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SWEEP_PERIOD:   prdata[2:0] = cfg.sweep_period;
      REG_SWEEP_SHIFT:    prdata[2:0] = cfg.sweep_shift;
      REG_SWEEP_SUBTRACT: prdata[0]   = cfg.sweep_subtract;
      REG_SQ1_ENV_PERIOD: prdata[2:0] = cfg.env_period[0];
      REG_SQ2_ENV_PERIOD: prdata[2:0] = cfg.env_period[1];
      REG_NOISE_ENV_PER:  prdata[2:0] = cfg.env_period[2];
      REG_ENV_RISE_MASK:  prdata[2:0] = cfg.env_rise_mask;
      default:            prdata      = '0;
    endcase
  end

endmodule

### rtl/core/sse_core.sv
`include "sound_sweep_envelope_sequencer_macros.svh"

module sse_core (
  input  logic          clk,
  input  logic          rst,
  input  sse_pkg::cfg_t cfg,
  // input transaction
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_cmd,
  input  logic [5:0]    in_cycles,
  input  logic [10:0]   in_load,
  input  logic [1:0]    in_chan,
  // result toward the output register
  output logic          res_valid,
  input  logic          res_ready,
  output sse_pkg::res_t res
);
  import sse_pkg::*;

  // Input register
  logic               s1_valid;
  cmd_t               s1_cmd;
  logic [CyclesW-1:0] s1_cycles;
  logic [FreqW-1:0]   s1_load;
  logic [1:0]         s1_chan;

  // Sequencer state
  logic [FreqW-1:0]             freq;
  logic [SweepW-1:0]            sweep_cnt;
  logic [NumEnv-1:0][EnvW-1:0]  env_cnt;
  logic [NumEnv-1:0][VolW-1:0]  env_vol;
  logic                         stop;

  logic [FreqW-1:0]             freq_next;
  logic [SweepW-1:0]            sweep_cnt_next;
  logic [NumEnv-1:0][EnvW-1:0]  env_cnt_next;
  logic [NumEnv-1:0][VolW-1:0]  env_vol_next;
  logic                         stop_next;
  logic                         updated;

  logic accept;
  logic adv;

  assign adv       = s1_valid && res_ready;
  assign in_ready  = !s1_valid || res_ready;
  assign accept    = in_valid && in_ready;
  assign res_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= cmd_t'(in_cmd);
      s1_cycles <= in_cycles;
      s1_load   <= in_load;
      s1_chan   <= in_chan;
    end
  end

  // Timer sums, sweep step and envelope steps for one item
  logic [SweepW:0]    sweep_sum;
  logic [SweepW-1:0]  sweep_sat;
  logic [20:0]        sweep_scaled;
  logic [20:0]        sweep_limit;
  logic [FreqW:0]     freq_up;
  logic [FreqW-1:0]   delta;
  logic [FreqW-1:0]   freq_step;
  logic               overflow;
  logic [EnvW:0]      env_sum;
  logic [EnvW-1:0]    env_sat;
  logic [EnvW-1:0]    env_limit;

  always_comb begin
    freq_next      = freq;
    sweep_cnt_next = sweep_cnt;
    env_cnt_next   = env_cnt;
    env_vol_next   = env_vol;
    stop_next      = stop;
    updated        = 1'b0;

    sweep_sum    = {1'b0, sweep_cnt} + (SweepW + 1)'(s1_cycles);
    sweep_sat    = sweep_sum[SweepW] ? {SweepW{1'b1}} : sweep_sum[SweepW-1:0];
    sweep_scaled = {3'b000, sweep_sat} + {1'b0, sweep_sat, 2'b00};
    sweep_limit  = {18'd0, cfg.sweep_period} * SweepUnit;
    delta        = freq >> cfg.sweep_shift;
    freq_up      = {1'b0, freq} + {1'b0, delta};
    overflow     = freq_up[FreqW];
    freq_step    = cfg.sweep_subtract ? (freq - delta) :
                   (overflow ? '0 : freq_up[FreqW-1:0]);
    env_sum      = '0;
    env_sat      = '0;
    env_limit    = '0;

    unique case (s1_cmd)
      CMD_TICK: begin
        // Sweep
        if (cfg.sweep_period == 3'd0) begin
          sweep_cnt_next = '0;
        end else if (sweep_scaled > sweep_limit) begin
          sweep_cnt_next = '0;
          freq_next      = freq_step;
          updated        = (freq_step != freq);
          if (!cfg.sweep_subtract && overflow) begin
            stop_next = 1'b1;
          end
        end else begin
          sweep_cnt_next = sweep_sat;
        end
        // Envelopes
        for (int c = 0; c < NumEnv; c++) begin
          env_sum   = {1'b0, env_cnt[c]} + (EnvW + 1)'(s1_cycles);
          env_sat   = env_sum[EnvW] ? {EnvW{1'b1}} : env_sum[EnvW-1:0];
          env_limit = {1'b0, cfg.env_period[c], 16'h0000};
          env_cnt_next[c] = env_sat;
          if ((cfg.env_period[c] != 3'd0) && (env_sat > env_limit)) begin
            env_cnt_next[c] = '0;
            if (cfg.env_rise_mask[c]) begin
              if (env_vol[c] != VolMax) env_vol_next[c] = env_vol[c] + 4'd1;
            end else if (env_vol[c] != 4'd0) begin
              env_vol_next[c] = env_vol[c] - 4'd1;
            end
          end
        end
      end
      CMD_LOAD_FREQ: begin
        freq_next = s1_load;
        stop_next = 1'b0;
      end
      CMD_LOAD_VOL: begin
        if (s1_chan != 2'd3) begin
          env_vol_next[s1_chan] = (s1_load > FreqW'(VolMax)) ? VolMax : s1_load[VolW-1:0];
        end
      end
      CMD_NOP: ;
      default: ;
    endcase
  end

  // State update on each item handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      freq      <= '0;
      sweep_cnt <= '0;
      env_cnt   <= '0;
      env_vol   <= '0;
      stop      <= 1'b0;
    end else if (adv) begin
      freq      <= freq_next;
      sweep_cnt <= sweep_cnt_next;
      env_cnt   <= env_cnt_next;
      env_vol   <= env_vol_next;
      stop      <= stop_next;
    end
  end

  // Result fields show the state after this item
  assign res.square1_freq    = freq_next;
  assign res.square1_volume  = env_vol_next[CH_SQUARE1];
  assign res.square2_volume  = env_vol_next[CH_SQUARE2];
  assign res.noise_volume    = env_vol_next[CH_NOISE];
  assign res.freq_updated    = updated;
  assign res.square1_stopped = stop_next;

  // A stalled item must not touch the state
  `SSE_ASSERT_NEXT(a_stall_holds_freq, clk, rst, s1_valid && !res_ready, $stable(freq))
  // Only ticks report a sweep step
  `SSE_ASSERT_NOW(a_update_only_tick, clk, rst, s1_valid && updated, s1_cmd == CMD_TICK)
  // Disabled sweep keeps its timer cleared
  `SSE_ASSERT_NEXT(a_sweep_off_clear, clk, rst,
    adv && (s1_cmd == CMD_TICK) && (cfg.sweep_period == 3'd0), sweep_cnt == '0)
  // Stop flag rises only through an upward sweep overflow
  `SSE_ASSERT_NEXT(a_stop_source, clk, rst, adv && !stop && stop_next,
    stop && (freq == '0))

endmodule

### rtl/core/sse_out.sv
module sse_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  output logic          res_ready,
  input  sse_pkg::res_t res,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata
);
  import sse_pkg::*;

  res_t hold;

  assign res_ready = !m_tvalid || m_tready;

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold <= res;
    end
  end

  assign m_tdata = {{(32 - $bits(res_t)){1'b0}}, hold};

endmodule
